// ----- sv/bba_pkg.sv -----
// Shared types, widths and a helper function for the bitmap block allocator.
// Used by the map cells, the cell ring and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  localparam int MAP_BYTES = 128;
  localparam int IDX_W     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int BYTE_W    = 8;
  localparam int ARG_W     = 21;
  localparam int DS_W      = 16;
  localparam int BLOCK_W   = 20;
  localparam int DIFF_W    = ARG_W + 2;
  localparam int BIDX_W    = DIFF_W - 4;

  localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hff;
  localparam logic              OP_ALLOC  = 1'b0;
  localparam logic              OP_FREE   = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_e;

  typedef struct packed {
    logic              shift;
    logic              wr;
    logic [BYTE_W-1:0] wr_byte;
  } ring_ctl_t;

  function automatic logic [2:0] lowest_zero(input logic [BYTE_W-1:0] v);
    logic [2:0] r;
    r = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (!v[i]) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/bba_cell.sv -----
// One byte of the free map, held in a cell of the rotating ring.
// Takes its neighbor's byte on a shift; depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bba_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       shift_i,
  input  wire logic [bba_pkg::BYTE_W-1:0] next_byte_i,
  input  wire logic                       wr_i,
  input  wire logic [bba_pkg::BYTE_W-1:0] wr_byte_i,
  output logic      [bba_pkg::BYTE_W-1:0] byte_o
);

  logic [bba_pkg::BYTE_W-1:0] byte_q;
  logic [bba_pkg::BYTE_W-1:0] byte_d;

  always_comb begin
    byte_d = byte_q;
    if (wr_i) begin
      byte_d = wr_byte_i;
    end else if (shift_i) begin
      byte_d = next_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

// ----- sv/bba_ring.sv -----
// Ring of map cells that rotates the free map past a single head cell.
// Instantiates bba_cell; depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bba_ring (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire bba_pkg::ring_ctl_t         ctl_i,
  output logic      [bba_pkg::BYTE_W-1:0] head_byte_o
);

  logic [bba_pkg::BYTE_W-1:0] bytes_w [bba_pkg::MAP_BYTES];

  for (genvar k = 0; k < bba_pkg::MAP_BYTES; k++) begin : g_cell
    localparam int NEXT = (k + 1) % bba_pkg::MAP_BYTES;
    logic wr_w;
    if (k == 0) begin : g_head
      assign wr_w = ctl_i.wr;
    end else begin : g_body
      assign wr_w = 1'b0;
    end
    bba_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (ctl_i.shift),
      .next_byte_i (bytes_w[NEXT]),
      .wr_i        (wr_w),
      .wr_byte_i   (ctl_i.wr_byte),
      .byte_o      (bytes_w[k])
    );
  end

  assign head_byte_o = bytes_w[0];

endmodule

`default_nettype wire

// ----- sv/bitmap_block_allocator.sv -----
// Top level of the bitmap first-fit block allocator: request control and result register.
// Instantiates bba_ring; depends on bba_pkg.
//
//   channel     direction  handshake                   payload
//   config      in         data_start_we_i             data_start_i
//   request     in         in_valid_i / in_ready_o     op_i, block_arg_i
//   result      out        out_valid_o / out_ready_i   status_o, blk_num_o
//
// While seeking or scanning, the map rotates one byte per cycle past the head cell, the only place
// it is read or written. After acceptance an allocation rotates the start byte to the head and
// checks it, scans forward byte by byte up to the last byte for a free bit, and then posts the
// result. A free rotates the target byte to the head, clears the bit there and then posts; an
// out-of-range request only posts. The next request is accepted in the cycle after posting.
// Reset clears the whole map at once; a stalled result holds the block in the posting step.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_block_allocator (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               data_start_we_i,
  input  wire logic        [bba_pkg::DS_W-1:0]    data_start_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic                               op_i,
  input  wire logic signed [bba_pkg::ARG_W-1:0]   block_arg_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic             [1:0]                  status_o,
  output logic             [bba_pkg::BLOCK_W-1:0] blk_num_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEEK   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_REPORT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [bba_pkg::DS_W-1:0]    data_start_q;
  logic [bba_pkg::IDX_W-1:0]   head_q, head_d;
  logic [bba_pkg::IDX_W-1:0]   target_q, target_d;
  logic [2:0]                  bit_q, bit_d;
  logic                        op_q, op_d;
  bba_pkg::status_e            res_status_q, res_status_d;
  logic [bba_pkg::BLOCK_W-1:0] res_block_q, res_block_d;
  logic                        out_valid_q, out_valid_d;
  bba_pkg::status_e            out_status_q, out_status_d;
  logic [bba_pkg::BLOCK_W-1:0] out_block_q, out_block_d;

  logic signed [bba_pkg::DIFF_W-1:0] diff_w;
  logic                              neg_w;
  logic [bba_pkg::BIDX_W-1:0]        bidx_w;
  logic                              in_map_w;
  logic                              accept_w;
  logic [bba_pkg::BYTE_W-1:0]        head_byte_w;
  logic [2:0]                        zero_bit_w;
  logic [bba_pkg::IDX_W-1:0]         head_inc_w;
  bba_pkg::ring_ctl_t                ring_ctl;

  assign accept_w   = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  assign diff_w   = $signed({{2{block_arg_i[bba_pkg::ARG_W-1]}}, block_arg_i})
                  - $signed({{(bba_pkg::DIFF_W - bba_pkg::DS_W){1'b0}}, data_start_q});
  assign neg_w    = diff_w[bba_pkg::DIFF_W-1];
  assign bidx_w   = diff_w[bba_pkg::DIFF_W-2:3];
  assign in_map_w = !neg_w && (bidx_w < bba_pkg::BIDX_W'(bba_pkg::MAP_BYTES));

  assign zero_bit_w = bba_pkg::lowest_zero(head_byte_w);
  assign head_inc_w = (head_q == bba_pkg::IDX_W'(bba_pkg::MAP_BYTES - 1)) ? '0 : head_q + 1'b1;

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    target_d     = target_q;
    bit_d        = bit_q;
    op_d         = op_q;
    res_status_d = res_status_q;
    res_block_d  = res_block_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_block_d  = out_block_q;
    ring_ctl     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept_w) begin
          op_d        = op_i;
          bit_d       = diff_w[2:0];
          target_d    = neg_w ? '0 : bidx_w[bba_pkg::IDX_W-1:0];
          res_block_d = '0;
          if (op_i == bba_pkg::OP_FREE) begin
            if (in_map_w) begin
              state_d = S_SEEK;
            end else begin
              res_status_d = bba_pkg::ST_OUTSIDE;
              state_d      = S_REPORT;
            end
          end else begin
            if (neg_w || in_map_w) begin
              state_d = S_SEEK;
            end else begin
              res_status_d = bba_pkg::ST_FULL;
              state_d      = S_REPORT;
            end
          end
        end
      end
      S_SEEK: begin
        if (head_q != target_q) begin
          ring_ctl.shift = 1'b1;
          head_d         = head_inc_w;
        end else if (op_q == bba_pkg::OP_FREE) begin
          ring_ctl.wr      = 1'b1;
          ring_ctl.wr_byte = head_byte_w & ~(bba_pkg::BYTE_W'(1) << bit_q);
          res_status_d     = bba_pkg::ST_DONE;
          state_d          = S_REPORT;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (head_byte_w != bba_pkg::FULL_BYTE) begin
          ring_ctl.wr      = 1'b1;
          ring_ctl.wr_byte = head_byte_w | (bba_pkg::BYTE_W'(1) << zero_bit_w);
          res_status_d     = bba_pkg::ST_DONE;
          res_block_d      = bba_pkg::BLOCK_W'({head_q, zero_bit_w})
                           + bba_pkg::BLOCK_W'(data_start_q);
          state_d          = S_REPORT;
        end else if (head_q == bba_pkg::IDX_W'(bba_pkg::MAP_BYTES - 1)) begin
          res_status_d = bba_pkg::ST_FULL;
          state_d      = S_REPORT;
        end else begin
          ring_ctl.shift = 1'b1;
          head_d         = head_inc_w;
        end
      end
      S_REPORT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_block_d  = res_block_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      out_valid_q  <= 1'b0;
      data_start_q <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
      if (data_start_we_i) begin
        data_start_q <= data_start_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    target_q     <= target_d;
    bit_q        <= bit_d;
    op_q         <= op_d;
    res_status_q <= res_status_d;
    res_block_q  <= res_block_d;
    out_status_q <= out_status_d;
    out_block_q  <= out_block_d;
  end

  bba_ring u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ring_ctl),
    .head_byte_o (head_byte_w)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign blk_num_o   = out_block_q;

`ifndef NO_ASSERTIONS
  a_no_shift_and_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ring_ctl.shift && ring_ctl.wr))
    else $error("Ring shifted and wrote the head cell in the same cycle.");

  a_scan_not_below_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (head_q >= target_q))
    else $error("Scan reached a byte below the start byte.");

  a_write_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_ctl.wr |-> (state_q == S_SEEK || state_q == S_SCAN))
    else $error("Map written outside a request.");

  a_failed_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != bba_pkg::ST_DONE) |-> (blk_num_o == '0))
    else $error("Failed request reported a nonzero block number.");

  a_seek_holds_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEEK && head_q == target_q) |-> !ring_ctl.shift)
    else $error("Ring rotated past the target byte.");
`endif

endmodule

`default_nettype wire
